// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// House form: clk_i / rst_ni of the enclosing module.
`define ASSERT_PROP(lbl, prop, msg) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/lscd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_pkg
// Constants, types and helpers of the link session close detector.
// ----------------------------------------------------------------------------
package lscd_pkg;

  localparam int NUM_SEATS = 4;
  localparam int WORD_W    = 16;
  localparam int TIME_W    = 32;
  localparam int SEAT_W    = 2;
  localparam int ROOM_W    = 3;
  localparam int CNT_W     = 3;
  localparam int FRAME_W   = 4;
  localparam int ARMF_W    = 7;
  localparam int ABS_W     = 2;

  localparam logic [WORD_W-1:0]  IDLE_WORD        = 16'hFFFF;
  localparam logic [WORD_W-1:0]  RUN_MAX          = 16'hFFFF;
  localparam logic [WORD_W-1:0]  RUN_THRESHOLD    = 16'd12;
  localparam logic [WORD_W-1:0]  SLAVE_MASK       = 16'hFFFC;
  localparam logic [TIME_W-1:0]  IDLE_UNARMED_MS  = 32'd30000;
  localparam logic [TIME_W-1:0]  HS_UNARMED_MS    = 32'd1000;
  localparam logic [ARMF_W-1:0]  ARM_DECAY_FRAMES = 7'd120;
  localparam logic [FRAME_W-1:0] WINDOW_FRAMES    = 4'd9;
  localparam logic [ABS_W-1:0]   ABSENT_LIMIT     = 2'd3;
  localparam logic [ROOM_W-1:0]  SEAT_LIMIT       = ROOM_W'(NUM_SEATS);

  // Config register indexes
  localparam logic [1:0] REG_LOCAL_SEAT = 2'd0;
  localparam logic [1:0] REG_ROOM_SIZE  = 2'd1;
  localparam logic [1:0] REG_SLAVE_HS   = 2'd2;
  localparam logic [1:0] REG_MASTER_HS  = 2'd3;

  localparam logic [WORD_W-1:0] MASTER_HS_RESET = 16'h8FFF;
  localparam logic [ROOM_W-1:0] ROOM_RESET      = 3'd2;

  // Slave-side tdata layout
  localparam int S_TDATA_W   = 120;
  localparam int I_RX        = 0;
  localparam int I_NOW       = 16;
  localparam int I_ARM       = 48;
  localparam int I_STAGED    = 49;

  // Master-side tdata layout
  localparam int M_TDATA_W   = 16;
  localparam int O_PHASE     = 0;
  localparam int O_PLAYERS   = 1;
  localparam int O_FRAME     = 4;
  localparam int O_PRESENT   = 8;
  localparam int O_WENT_EST  = 9;
  localparam int O_WENT_HS   = 10;
  localparam int O_USED      = 11;

  typedef logic [NUM_SEATS-1:0][WORD_W-1:0] seat_words_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] first;
  } scan_t;

  function automatic logic is_hs_word(input logic [WORD_W-1:0] w,
                                      input logic [WORD_W-1:0] slave,
                                      input logic [WORD_W-1:0] master);
    is_hs_word = ((w & SLAVE_MASK) == slave) || (w == master);
  endfunction

endpackage

// File: hdl/lscd_seat_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_seat_scan
// Counts leading handshake words across the seat matrix.
// ----------------------------------------------------------------------------
module lscd_seat_scan
  import lscd_pkg::*;
(
  input  logic [WORD_W-1:0] rx_word_i,
  input  seat_words_t       staged_i,
  input  logic [SEAT_W-1:0] local_seat_i,
  input  logic [ROOM_W-1:0] room_size_i,
  input  logic [WORD_W-1:0] slave_word_i,
  input  logic [WORD_W-1:0] master_word_i,
  output scan_t             scan_o
);

  logic [ROOM_W-1:0] seats;
  logic [WORD_W-1:0] w;
  logic              stop;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] first;

  assign seats = (room_size_i > SEAT_LIMIT) ? SEAT_LIMIT : room_size_i;

  // Walk the seats in order; an idle word ends the run keeping the count,
  // any other non-handshake word ends it with count zero.
  always_comb begin
    stop  = 1'b0;
    cnt   = '0;
    first = IDLE_WORD;
    w     = '0;
    for (int s = 0; s < NUM_SEATS; s++) begin
      w = (SEAT_W'(s) == local_seat_i) ? rx_word_i : staged_i[s];
      if (!stop && (ROOM_W'(s) < seats)) begin
        if (s == 0) begin
          first = w;
        end
        if (is_hs_word(w, slave_word_i, master_word_i)) begin
          cnt = cnt + CNT_W'(1);
        end else begin
          if (w != IDLE_WORD) begin
            cnt = '0;
          end
          stop = 1'b1;
        end
      end
    end
  end

  assign scan_o.count = cnt;
  assign scan_o.first = first;

endmodule

// File: hdl/link_session_close_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_session_close_detector_top
// Per-transfer session tracker: handshake detection, establishment and
// close detection from idle / handshake runs.
// ----------------------------------------------------------------------------
//
//  channel   dir  bus                         content
//  --------  ---  --------------------------  ------------------------------
//  s_axis    in   tvalid/tready/tdata[119:0]  one completed link transfer
//  m_axis    out  tvalid/tready/tdata[15:0]   session status for it
//  cfg       in   we/idx[1:0]/wdata[15:0]     seat, room, handshake words
//
//  Each transaction passes the input register, then the result register;
//  one transaction per cycle is sustained while m_axis_tready stays high.
//  The state update is a single pass through the seat scan and one 32-bit
//  wrapping subtract + compare shared by both runs, between the two registers.
//  Input stalls only when both the input and result registers are full and
//  m_axis_tready is low. Reset is async, active low; no clearing pass.
//  Config writes are expected only while no transaction is in flight.
// ----------------------------------------------------------------------------
module link_session_close_detector_top
  import lscd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // cfg
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] rx_word, [47:16] now_ms, [48] close_arm, [64:49] staged_seat0,
  // [80:65] staged_seat1, [96:81] staged_seat2, [112:97] staged_seat3, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] phase_established, [3:1] player_count, [7:4] frame_index,
  // [8] cart_present, [9] went_established, [10] went_handshake, zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  // --- configuration registers ---
  logic [SEAT_W-1:0] local_seat_q;
  logic [ROOM_W-1:0] room_size_q;
  logic [WORD_W-1:0] slave_word_q, master_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_seat_q  <= '0;
      room_size_q   <= ROOM_RESET;
      slave_word_q  <= '0;
      master_word_q <= MASTER_HS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOCAL_SEAT: local_seat_q  <= cfg_wdata_i[SEAT_W-1:0];
        REG_ROOM_SIZE:  room_size_q   <= cfg_wdata_i[ROOM_W-1:0];
        REG_SLAVE_HS:   slave_word_q  <= cfg_wdata_i;
        REG_MASTER_HS:  master_word_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // --- handshake / flow control ---
  logic in_vld_q, m_vld_q;
  logic out_room, proc, s_acc;

  assign out_room      = !m_vld_q || m_axis_tready;
  assign proc          = in_vld_q && out_room;
  assign s_axis_tready = !in_vld_q || out_room;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // --- input register (payload, no reset) ---
  logic [WORD_W-1:0] rx_q;
  logic [TIME_W-1:0] now_q;
  logic              arm_q;
  seat_words_t       staged_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      rx_q  <= s_axis_tdata[I_RX +: WORD_W];
      now_q <= s_axis_tdata[I_NOW +: TIME_W];
      arm_q <= s_axis_tdata[I_ARM];
      for (int s = 0; s < NUM_SEATS; s++) begin
        staged_q[s] <= s_axis_tdata[I_STAGED + s*WORD_W +: WORD_W];
      end
    end
  end

  // --- session state ---
  logic               phase_q, phase_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [CNT_W-1:0]   players_q, players_d;
  logic [WORD_W-1:0]  idle_run_q, idle_run_d;
  logic [TIME_W-1:0]  idle_start_q, idle_start_d;
  logic [WORD_W-1:0]  hs_run_q, hs_run_d;
  logic [TIME_W-1:0]  hs_start_q, hs_start_d;
  logic               armed_q, armed_d;
  logic [ARMF_W-1:0]  armf_q, armf_d;
  logic               present_q, present_d;
  logic [ABS_W-1:0]   absent_q, absent_d;
  logic [CNT_W-1:0]   prev_cnt_q, prev_cnt_d;
  logic               went_est, went_hs;

  scan_t scan;

  lscd_seat_scan u_scan (
    .rx_word_i    (rx_q),
    .staged_i     (staged_q),
    .local_seat_i (local_seat_q),
    .room_size_i  (room_size_q),
    .slave_word_i (slave_word_q),
    .master_word_i(master_word_q),
    .scan_o       (scan)
  );

  logic              rx_hs, rx_idle, arm_now, fire;
  logic [WORD_W-1:0] run_inc;
  logic [TIME_W-1:0] run_start, elapsed, min_ms;
  logic [ARMF_W-1:0] armf_inc;
  logic [FRAME_W-1:0] frame_inc;

  assign rx_hs     = is_hs_word(rx_q, slave_word_q, master_word_q);
  assign rx_idle   = (rx_q == IDLE_WORD);
  // close announce only counts at a window boundary
  assign arm_now   = (frame_q == '0) && arm_q;
  assign frame_inc = frame_q + FRAME_W'(1);

  // One saturating run counter and one wrapping time check serve whichever
  // run (idle or handshake) the received word extends.
  always_comb begin
    if (rx_idle) begin
      run_inc   = (idle_run_q != RUN_MAX) ? idle_run_q + WORD_W'(1) : idle_run_q;
      run_start = (idle_run_q == '0) ? now_q : idle_start_q;
      min_ms    = IDLE_UNARMED_MS;
    end else begin
      run_inc   = (hs_run_q != RUN_MAX) ? hs_run_q + WORD_W'(1) : hs_run_q;
      run_start = (hs_run_q == '0) ? now_q : hs_start_q;
      min_ms    = HS_UNARMED_MS;
    end
  end

  assign elapsed = now_q - run_start;

  always_comb begin
    phase_d      = phase_q;
    frame_d      = frame_q;
    players_d    = players_q;
    idle_run_d   = idle_run_q;
    idle_start_d = idle_start_q;
    hs_run_d     = hs_run_q;
    hs_start_d   = hs_start_q;
    armed_d      = armed_q;
    armf_d       = armf_q;
    present_d    = present_q;
    absent_d     = absent_q;
    prev_cnt_d   = prev_cnt_q;
    went_est     = 1'b0;
    went_hs      = 1'b0;
    fire         = 1'b0;
    armf_inc     = '0;

    if (phase_q) begin
      // established: arm, track runs, detect close
      if (arm_now) begin
        armed_d = 1'b1;
        armf_d  = '0;
      end
      if (rx_idle) begin
        hs_run_d     = '0;
        idle_run_d   = run_inc;
        idle_start_d = run_start;
        fire = (run_inc >= RUN_THRESHOLD) && (armed_d || (elapsed >= min_ms));
      end else if (rx_hs) begin
        idle_run_d = '0;
        hs_run_d   = run_inc;
        hs_start_d = run_start;
        fire = (run_inc >= RUN_THRESHOLD) && (armed_d || (elapsed >= min_ms));
      end else begin
        idle_run_d = '0;
        hs_run_d   = '0;
        present_d  = 1'b1;
        if (armed_d) begin
          armf_inc = armf_d + ARMF_W'(1);
          if (armf_inc >= ARM_DECAY_FRAMES) begin
            armed_d = 1'b0;
            armf_d  = '0;
          end else begin
            armf_d  = armf_inc;
          end
        end
      end

      if (fire) begin
        // close: back to handshake, run start stamps are kept
        went_hs    = 1'b1;
        phase_d    = 1'b0;
        frame_d    = '0;
        prev_cnt_d = '0;
        players_d  = '0;
        present_d  = 1'b0;
        absent_d   = '0;
        idle_run_d = '0;
        hs_run_d   = '0;
        armed_d    = 1'b0;
        armf_d     = '0;
      end else begin
        if ((idle_run_d >= RUN_THRESHOLD) || (hs_run_d >= RUN_THRESHOLD)) begin
          present_d = 1'b0;
        end
        frame_d = (frame_inc >= WINDOW_FRAMES) ? '0 : frame_inc;
      end
    end else begin
      // handshake: presence debounce and establishment detection
      if (rx_hs) begin
        absent_d  = '0;
        present_d = 1'b1;
      end else if (present_q) begin
        absent_d = (absent_q < ABSENT_LIMIT) ? absent_q + ABS_W'(1) : absent_q;
        if (absent_d >= ABSENT_LIMIT) begin
          present_d = 1'b0;
        end
      end

      if ((scan.count > CNT_W'(1)) && (scan.count == prev_cnt_q) &&
          (scan.first == master_word_q) && rx_hs) begin
        went_est   = 1'b1;
        players_d  = scan.count;
        frame_d    = '0;
        idle_run_d = '0;
        hs_run_d   = '0;
        armed_d    = 1'b0;
        armf_d     = '0;
        present_d  = 1'b1;
        phase_d    = 1'b1;
      end else begin
        prev_cnt_d = scan.count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      m_vld_q      <= 1'b0;
      phase_q      <= 1'b0;
      frame_q      <= '0;
      players_q    <= '0;
      idle_run_q   <= '0;
      idle_start_q <= '0;
      hs_run_q     <= '0;
      hs_start_q   <= '0;
      armed_q      <= 1'b0;
      armf_q       <= '0;
      present_q    <= 1'b0;
      absent_q     <= '0;
      prev_cnt_q   <= '0;
    end else begin
      if (s_acc) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end

      if (proc) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end

      if (proc) begin
        phase_q      <= phase_d;
        frame_q      <= frame_d;
        players_q    <= players_d;
        idle_run_q   <= idle_run_d;
        idle_start_q <= idle_start_d;
        hs_run_q     <= hs_run_d;
        hs_start_q   <= hs_start_d;
        armed_q      <= armed_d;
        armf_q       <= armf_d;
        present_q    <= present_d;
        absent_q     <= absent_d;
        prev_cnt_q   <= prev_cnt_d;
      end
    end
  end

  // --- result register (payload, no reset) ---
  logic [M_TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i) begin
    if (proc) begin
      m_data_q <= {(M_TDATA_W-O_USED)'(0), went_hs, went_est, present_d,
                   frame_d, players_d, phase_d};
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: hdl/lscd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_checker
// Port-level checks on the session status stream; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lscd_checker
  import lscd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic               phase, present, went_est, went_hs;
  logic [CNT_W-1:0]   players;
  logic [FRAME_W-1:0] frame;
  logic               stall, close_ok, est_ok, idle_ok, range_ok;

  assign phase    = m_axis_tdata[O_PHASE];
  assign players  = m_axis_tdata[O_PLAYERS +: CNT_W];
  assign frame    = m_axis_tdata[O_FRAME +: FRAME_W];
  assign present  = m_axis_tdata[O_PRESENT];
  assign went_est = m_axis_tdata[O_WENT_EST];
  assign went_hs  = m_axis_tdata[O_WENT_HS];

  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign close_ok = !phase && !went_est && (players == '0) && (frame == '0) && !present;
  assign est_ok   = phase && present && (frame == '0) && (players > CNT_W'(1));
  assign idle_ok  = (players == '0) && (frame == '0);
  assign range_ok = (frame < WINDOW_FRAMES) && (players <= CNT_W'(NUM_SEATS));

  `ASSERT_PROP(a_stall_hold, stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stall broken")
  `ASSERT_PROP(a_close_clears, m_axis_tvalid && went_hs |-> close_ok, "close left session state")
  `ASSERT_PROP(a_est_shape, m_axis_tvalid && went_est |-> est_ok, "bad establish result")
  `ASSERT_PROP(a_hs_phase_idle, m_axis_tvalid && !phase |-> idle_ok, "session data in handshake")
  `ASSERT_PROP(a_frame_range, m_axis_tvalid |-> range_ok, "frame or player count out of range")

endmodule

bind link_session_close_detector_top lscd_checker u_lscd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// File: dv/link_session_close_detector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_session_close_detector_top_tb
// Self-checking bench for the session close detector. A queue-fed driver
// sends link transfers with random gaps and a monitor with random
// back-pressure checks every status transaction against an in-bench model
// of the session tracker.
// ----------------------------------------------------------------------------
module link_session_close_detector_top_tb;
  import lscd_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 4;
  // Longest legal quiet stretch: sender gap + receiver stall + the input and
  // result registers + a config pause; the limit is many times that.
  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_ITEMS    = 75;

  // One link transfer as the bench sees it, plus the idle gap before it.
  typedef struct {
    logic [WORD_W-1:0] rx;
    logic [TIME_W-1:0] now;
    logic              arm;
    seat_words_t       staged;
    int unsigned       gap;
  } xfer_t;

  // Mirrors m_axis_tdata[10:0]; first member lands in the top bit.
  typedef struct packed {
    logic               went_hs;
    logic               went_est;
    logic               present;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   players;
    logic               established;
  } status_t;

  // --------------------------------------------------------------------------
  // DUT ports, all driven to known values from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [1:0]           cfg_idx_i     = REG_LOCAL_SEAT;
  logic [WORD_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  link_session_close_detector_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench bookkeeping
  // --------------------------------------------------------------------------
  xfer_t       xfer_q[$];      // transfers waiting to be driven
  status_t     status_q[$];    // predicted status, oldest first
  int          errors         = 0;
  int          items_sent     = 0;
  int          results_seen   = 0;
  int          sessions_open  = 0;
  int          sessions_close = 0;
  int          queued_items   = 0;
  int          quiet_cycles   = 0;
  logic        s_taken        = 1'b0;  // input transaction at the last rising edge
  logic        m_taken        = 1'b0;  // output transaction at the last rising edge
  bit          steady_tx      = 1'b0;  // sender runs back to back
  bit          steady_rx      = 1'b0;  // receiver never stalls
  int unsigned gap_left       = 0;
  bit          gap_loaded     = 1'b0;
  int unsigned stall_left     = 0;
  logic [TIME_W-1:0] wall_ms  = '0;    // bench millisecond clock for now_ms

  // --------------------------------------------------------------------------
  // Session model: config copies and state, at reset values
  // --------------------------------------------------------------------------
  logic [SEAT_W-1:0]  reg_local_seat = '0;
  logic [ROOM_W-1:0]  reg_room       = ROOM_RESET;
  logic [WORD_W-1:0]  reg_slave_hs   = '0;
  logic [WORD_W-1:0]  reg_master_hs  = MASTER_HS_RESET;

  logic               sess_established = 1'b0;
  logic [FRAME_W-1:0] sess_frame       = '0;
  logic [CNT_W-1:0]   sess_players     = '0;
  logic [WORD_W-1:0]  idle_len         = '0;
  logic [TIME_W-1:0]  idle_t0          = '0;
  logic [WORD_W-1:0]  hs_len           = '0;
  logic [TIME_W-1:0]  hs_t0            = '0;
  logic               arm_set          = 1'b0;
  logic [ARMF_W-1:0]  arm_frames       = '0;
  logic               cart_seen        = 1'b0;
  logic [ABS_W-1:0]   absent_len       = '0;
  logic [CNT_W-1:0]   last_count       = '0;

  // Slave words match with the low two bits masked off, master exactly.
  function automatic bit hs_word(input logic [WORD_W-1:0] w);
    return ({w[WORD_W-1:2], 2'b00} == reg_slave_hs) || (w == reg_master_hs);
  endfunction

  task automatic apply_reg(input logic [1:0] idx, input logic [WORD_W-1:0] val);
    case (idx)
      REG_LOCAL_SEAT: reg_local_seat = val[SEAT_W-1:0];
      REG_ROOM_SIZE:  reg_room       = val[ROOM_W-1:0];
      REG_SLAVE_HS:   reg_slave_hs   = val;
      REG_MASTER_HS:  reg_master_hs  = val;
      default: ;
    endcase
  endtask

  // Advance the model by one transfer and queue the status it produces.
  task automatic predict_status(input xfer_t x);
    status_t           res;
    bit                fire;
    bit                opened;
    bit                scanning;
    int                seats;
    int                count;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] first;
    fire   = 1'b0;
    opened = 1'b0;
    if (sess_established) begin
      // close_arm only counts at a window boundary
      if (sess_frame == 0 && x.arm) begin
        arm_set    = 1'b1;
        arm_frames = '0;
      end
      if (x.rx == IDLE_WORD) begin
        hs_len = '0;
        if (idle_len == 0) idle_t0 = x.now;
        if (idle_len != RUN_MAX) idle_len++;
        fire = (idle_len >= RUN_THRESHOLD) &&
               (arm_set || ((x.now - idle_t0) >= IDLE_UNARMED_MS));
      end else if (hs_word(x.rx)) begin
        idle_len = '0;
        if (hs_len == 0) hs_t0 = x.now;
        if (hs_len != RUN_MAX) hs_len++;
        fire = (hs_len >= RUN_THRESHOLD) &&
               (arm_set || ((x.now - hs_t0) >= HS_UNARMED_MS));
      end else begin
        // normal traffic: runs restart, arm decays
        idle_len  = '0;
        hs_len    = '0;
        cart_seen = 1'b1;
        if (arm_set) begin
          arm_frames++;
          if (arm_frames >= ARM_DECAY_FRAMES) begin
            arm_set    = 1'b0;
            arm_frames = '0;
          end
        end
      end
      if (fire) begin
        // close: everything but the run start stamps goes back to reset
        sess_established = 1'b0;
        sess_frame       = '0;
        last_count       = '0;
        sess_players     = '0;
        cart_seen        = 1'b0;
        absent_len       = '0;
        idle_len         = '0;
        hs_len           = '0;
        arm_set          = 1'b0;
        arm_frames       = '0;
        sessions_close++;
      end else begin
        if (idle_len >= RUN_THRESHOLD || hs_len >= RUN_THRESHOLD) cart_seen = 1'b0;
        sess_frame = (sess_frame >= WINDOW_FRAMES - 1) ? '0 : sess_frame + 1'b1;
      end
    end else begin
      // presence debounce on the local cart
      if (hs_word(x.rx)) begin
        absent_len = '0;
        cart_seen  = 1'b1;
      end else if (cart_seen) begin
        if (absent_len != ABSENT_LIMIT) absent_len++;
        if (absent_len >= ABSENT_LIMIT) cart_seen = 1'b0;
      end
      // leading handshake words across the seat matrix
      seats    = (reg_room > NUM_SEATS) ? NUM_SEATS : int'(reg_room);
      first    = IDLE_WORD;
      count    = 0;
      scanning = 1'b1;
      for (int s = 0; s < seats; s++) begin
        if (scanning) begin
          w = (s == int'(reg_local_seat)) ? x.rx : x.staged[s];
          if (s == 0) first = w;
          if (hs_word(w)) begin
            count++;
          end else begin
            if (w != IDLE_WORD) count = 0;
            scanning = 1'b0;
          end
        end
      end
      if (count > 1 && count == int'(last_count) && first == reg_master_hs &&
          hs_word(x.rx)) begin
        sess_players     = CNT_W'(count);
        sess_frame       = '0;
        idle_len         = '0;
        hs_len           = '0;
        arm_set          = 1'b0;
        arm_frames       = '0;
        cart_seen        = 1'b1;
        sess_established = 1'b1;
        opened           = 1'b1;
        sessions_open++;
      end else begin
        last_count = CNT_W'(count);
      end
    end
    res.established = sess_established;
    res.players     = sess_players;
    res.frame       = sess_frame;
    res.present     = cart_seen;
    res.went_est    = opened;
    res.went_hs     = fire;
    status_q.push_back(res);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: one transfer per transaction, gap drawn per item, all changes
  // at the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    xfer_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_taken) begin
        if (xfer_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          if (!gap_loaded) begin
            gap_left   = xfer_q[0].gap;
            gap_loaded = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
          end else begin
            nxt        = xfer_q.pop_front();
            gap_loaded = 1'b0;
            s_axis_tdata  <= {7'd0, nxt.staged, nxt.arm, nxt.now, nxt.rx};
            s_axis_tvalid <= 1'b1;
          end
        end
      end
    end
  end

  // Receiver back-pressure: a stall drawn at random after each result, with
  // stretches of no stall at all.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_taken) begin
        stall_left = steady_rx ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 47) == 0) steady_rx = !steady_rx;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples at the rising edge, runs the model on each input
  // transaction and checks each output transaction; also the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    status_t want;
    status_t got;
    xfer_t   x;
    if (rst_ni) begin
      s_taken <= s_axis_tvalid && s_axis_tready;
      m_taken <= m_axis_tvalid && m_axis_tready;
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_wdata_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = status_t'(m_axis_tdata[O_USED-1:0]);
        results_seen++;
        if (status_q.size() == 0) begin
          $error("status transaction with nothing expected: %h", m_axis_tdata);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("phase_established", int'(want.established), int'(got.established));
          check_field("player_count", int'(want.players), int'(got.players));
          check_field("frame_index", int'(want.frame), int'(got.frame));
          check_field("cart_present", int'(want.present), int'(got.present));
          check_field("went_established", int'(want.went_est), int'(got.went_est));
          check_field("went_handshake", int'(want.went_hs), int'(got.went_hs));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        x.rx     = s_axis_tdata[15:0];
        x.now    = s_axis_tdata[47:16];
        x.arm    = s_axis_tdata[48];
        x.staged = s_axis_tdata[112:49];
        x.gap    = 0;
        predict_status(x);
        items_sent++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("link_session_close_detector_top_tb: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic queue_xfer(input logic [WORD_W-1:0] rx, input logic [WORD_W-1:0] s0,
                            input logic [WORD_W-1:0] s1, input logic [WORD_W-1:0] s2,
                            input logic [WORD_W-1:0] s3, input logic arm,
                            input logic [TIME_W-1:0] step_ms);
    xfer_t x;
    wall_ms  = wall_ms + step_ms;
    x.rx     = rx;
    x.now    = wall_ms;
    x.arm    = arm;
    x.staged = {s3, s2, s1, s0};
    x.gap    = steady_tx ? 0 : $urandom_range(0, 7);
    xfer_q.push_back(x);
    queued_items++;
  endtask

  // A word the block takes as a handshake under the current setting.
  function automatic logic [WORD_W-1:0] hs_sample();
    logic [1:0] low;
    low = 2'($urandom_range(0, 3));
    if (reg_slave_hs[1:0] != 2'b00 || $urandom_range(0, 3) == 0) return reg_master_hs;
    return {reg_slave_hs[WORD_W-1:2], low};
  endfunction

  // Ordinary traffic: neither idle nor a handshake.
  function automatic logic [WORD_W-1:0] data_sample();
    logic [WORD_W-1:0] w;
    w = rand_word();
    while (w == IDLE_WORD || hs_word(w)) w = rand_word();
    return w;
  endfunction

  // Handshake transfers that should establish, some traffic, then usually a close
  // by an idle run or a handshake run, armed or on elapsed time.
  task automatic queue_session();
    int                seats;
    int                players;
    int                body;
    int                run_len;
    int                close_kind;
    int                pick;
    bit                long_body;
    seat_words_t       m;
    logic [WORD_W-1:0] rx;
    logic [WORD_W-1:0] w;
    steady_tx = ($urandom_range(0, 3) == 0);
    seats     = (reg_room > NUM_SEATS) ? NUM_SEATS : int'(reg_room);
    players   = (seats >= 2) ? $urandom_range(2, seats) : 2;
    m[0]      = reg_master_hs;
    for (int s = 1; s < NUM_SEATS; s++) begin
      if (s < players) m[s] = hs_sample();
      else m[s] = ($urandom_range(0, 7) == 0) ? data_sample() : IDLE_WORD;
    end
    rx = (reg_local_seat == 0) ? reg_master_hs : hs_sample();
    repeat ($urandom_range(2, 3))
      queue_xfer(rx, m[0], m[1], m[2], m[3], rand_bit(), $urandom_range(0, 50));

    // long bodies let an arm taken at the first window decay
    long_body = ($urandom_range(0, 9) == 0);
    body      = long_body ? $urandom_range(125, 135) : $urandom_range(0, 25);
    for (int i = 0; i < body; i++) begin
      pick = $urandom_range(0, 9);
      if (long_body || pick < 7) w = data_sample();
      else if (pick == 7) w = IDLE_WORD;
      else if (pick == 8) w = hs_sample();
      else w = rand_word();
      queue_xfer(w, rand_word(), rand_word(), rand_word(), rand_word(),
                 long_body ? (i == 0) : ($urandom_range(0, 5) == 0),
                 $urandom_range(0, 100));
    end

    close_kind = $urandom_range(0, 3);
    run_len    = $urandom_range(10, 16);
    if (close_kind != 2) begin
      for (int i = 0; i < run_len; i++) begin
        if (close_kind == 1)
          queue_xfer(hs_sample(), rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_bit(), $urandom_range(0, 200));
        else
          queue_xfer(IDLE_WORD, rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_bit(),
                     (close_kind == 3) ? $urandom_range(2000, 4000) : $urandom_range(0, 4000));
      end
    end
  endtask

  // Unstructured transfers, with the odd large jump of the millisecond clock.
  task automatic queue_noise();
    int                pick;
    logic [WORD_W-1:0] w;
    steady_tx = ($urandom_range(0, 1) == 0);
    repeat ($urandom_range(3, 10)) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) w = IDLE_WORD;
      else if (pick == 1) w = hs_sample();
      else w = rand_word();
      queue_xfer(w,
                 ($urandom_range(0, 1) == 0) ? hs_sample() : rand_word(),
                 ($urandom_range(0, 1) == 0) ? hs_sample() : rand_word(),
                 rand_word(), rand_word(), rand_bit(),
                 ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic write_all(input logic [1:0] seat, input logic [ROOM_W-1:0] room,
                           input logic [WORD_W-1:0] slave, input logic [WORD_W-1:0] master);
    write_reg(REG_LOCAL_SEAT, WORD_W'(seat));
    write_reg(REG_ROOM_SIZE, WORD_W'(room));
    write_reg(REG_SLAVE_HS, slave);
    write_reg(REG_MASTER_HS, master);
  endtask

  // Every transfer yields one status, so an empty expectation queue means
  // the block is idle; a wait of SETTLE_CYCLES follows before returning.
  task automatic wait_drained();
    while (xfer_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [1:0] seat, input logic [ROOM_W-1:0] room,
                           input logic [WORD_W-1:0] slave, input logic [WORD_W-1:0] master);
    wait_drained();
    write_all(seat, room, slave, master);
    queued_items = 0;
    while (queued_items < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 7) queue_session();
      else queue_noise();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: seat 0, two seats, slave 0, master 0x8FFF.
    queue_xfer(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd0);
    queue_xfer(16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'hFFFF_FFF0);
    queue_xfer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'd15);
    // third miss in a row drops presence; clock wraps to zero here
    queue_xfer(16'hABCD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd1);
    // slave word with its low bits set still counts; second one establishes
    queue_xfer(16'h8FFF, 16'h0000, 16'h0003, 16'hFFFF, 16'hFFFF, 1'b0, 32'd5);
    queue_xfer(16'h8FFF, 16'h0000, 16'h0003, 16'hFFFF, 16'hFFFF, 1'b0, 32'd5);
    // arm at the window boundary, then an armed idle run of twelve closes
    queue_xfer(16'h5555, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 1'b1, 32'd3);
    repeat (12)
      queue_xfer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd1);
    queue_xfer(16'h0001, 16'h8FFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'd1);

    // Random part across settings, extremes among them.
    run_phase(2'd1, 3'd4, 16'h1234, 16'hABCD);
    run_phase(2'd3, 3'd7, 16'hFFFC, 16'hFFFF);  // oversized room, idle is a handshake
    run_phase(2'd2, 3'd3, 16'h0000, 16'h0000);
    run_phase(2'd3, 3'd2, 16'h0003, 16'h8FFF);  // local seat outside room, dead slave
    run_phase(2'd0, 3'd0, 16'hFFFF, 16'h0001);  // empty room
    run_phase(2'd2, 3'd1, 16'h5550, 16'h7FFF);  // single seat never establishes
    run_phase(2'd0, 3'd4, 16'h0000, 16'h8FFF);
    wait_drained();

    $display("covered %0d transfers, %0d status transactions checked",
             items_sent, results_seen);
    $display("sessions opened %0d, closes detected %0d, mismatches %0d",
             sessions_open, sessions_close, errors);
    if (errors == 0) begin
      $display("link_session_close_detector_top_tb: clean");
    end else begin
      $display("link_session_close_detector_top_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/lscd_pkg.sv
hdl/lscd_seat_scan.sv
hdl/link_session_close_detector_top.sv
hdl/lscd_checker.sv
dv/link_session_close_detector_top_tb.sv
